// ===== rtl/core/hpr_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package hpr_pkg;

  localparam int unsigned PtrW            = 64;
  localparam int unsigned DefThreads      = 4;
  localparam int unsigned DefSlots        = 4;
  localparam int unsigned DefRetireDepth  = 16;
  localparam int unsigned SelW            = 4;

  typedef enum logic [1:0] {
    CMD_PROTECT   = 2'd0,
    CMD_CLEAR_ONE = 2'd1,
    CMD_CLEAR_ROW = 2'd2,
    CMD_RETIRE    = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    KIND_ACK      = 2'd0,
    KIND_FREED    = 2'd1,
    KIND_OVERFLOW = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_TAIL,
    ST_FINAL
  } state_e;

  typedef struct packed {
    cmd_e            cmd;
    logic [1:0]      thread_id;
    logic [1:0]      slot_index;
    logic [PtrW-1:0] pointer_value;
  } in_t;

  typedef struct packed {
    logic [1:0]      kind;
    logic [PtrW-1:0] value;
    logic            last;
  } out_t;

  typedef struct packed {
    logic            en;
    logic            whole_row;
    logic [SelW-1:0] row;
    logic [SelW-1:0] col;
    logic [PtrW-1:0] data;
  } slot_wr_t;

endpackage

`default_nettype wire

// ===== rtl/core/hazard_pointer_reclaimer.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Channel  Direction  Handshake                Payload
// in       input      in_valid_i / in_ready_o  in_data_i  (hpr_pkg::in_t)
// out      output     out_valid_o / out_ready_i out_data_o (hpr_pkg::out_t)
//
// Protect and clear commands take one cycle and give one result.
// A retire scans the entries already listed for its thread; each is read from the
// list memory and compared against all hazard slots, survivors written back in
// place; the new pointer is then kept if held, freed if not, or refused if full.
// Reset clears the hazard slots and the list counts; no clearing pass is needed.
// A stalled output holds the scan; the input is taken only while the block is idle.

module hazard_pointer_reclaimer #(
  parameter int unsigned THREADS      = hpr_pkg::DefThreads,
  parameter int unsigned SLOTS        = hpr_pkg::DefSlots,
  parameter int unsigned RETIRE_DEPTH = hpr_pkg::DefRetireDepth
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_valid_i,
  output logic                in_ready_o,
  input  wire hpr_pkg::in_t   in_data_i,
  output logic                out_valid_o,
  input  wire logic           out_ready_i,
  output hpr_pkg::out_t       out_data_o
);

  import hpr_pkg::*;

  localparam int unsigned TW      = (THREADS > 1) ? $clog2(THREADS) : 1;
  localparam int unsigned IW      = $clog2(RETIRE_DEPTH);
  localparam int unsigned CW      = $clog2(RETIRE_DEPTH + 1);
  localparam int unsigned Entries = THREADS * RETIRE_DEPTH;
  localparam int unsigned AW      = $clog2(Entries);

  state_e          state_q, state_d;
  logic [TW-1:0]   tid_q, tid_d;
  logic [PtrW-1:0] ptr_q, ptr_d;
  logic [CW-1:0]   cnt_q, cnt_d;
  logic [CW-1:0]   rd_q, rd_d;
  logic [CW-1:0]   wr_q, wr_d;
  logic            rej_q, rej_d;
  logic            chk_v_q, chk_v_d;
  logic [CW-1:0]   counts_q [THREADS];
  logic            cnt_we;
  out_t            out_q;
  logic            out_valid_q;

  logic            out_free;
  logic            emit;
  out_t            emit_data;
  logic            tid_ok;
  logic            slot_ok;
  logic [TW-1:0]   in_tid;
  logic            adv;
  slot_wr_t        tbl_wr;
  logic [PtrW-1:0] query;
  logic            hit;
  logic [AW-1:0]   base;
  logic            mem_we;
  logic [AW-1:0]   mem_waddr;
  logic [PtrW-1:0] mem_wdata;
  logic            mem_re;
  logic [AW-1:0]   mem_raddr;
  logic [PtrW-1:0] mem_rdata;

  hpr_hazard_table #(
    .THREADS (THREADS),
    .SLOTS   (SLOTS)
  ) u_table (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_i    (tbl_wr),
    .query_i (query),
    .hit_o   (hit)
  );

  hpr_retire_mem #(
    .ENTRIES (Entries),
    .AW      (AW)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  assign out_free = !out_valid_q || out_ready_i;
  assign tid_ok   = {3'b000, in_data_i.thread_id} < 5'(THREADS);
  assign slot_ok  = {3'b000, in_data_i.slot_index} < 5'(SLOTS);
  assign in_tid   = TW'(in_data_i.thread_id);
  assign base     = AW'(tid_q) * AW'(RETIRE_DEPTH);
  assign query    = (state_q == ST_TAIL) ? ptr_q : mem_rdata;
  assign adv      = !(chk_v_q && !hit && !out_free);

  always_comb begin
    state_d    = state_q;
    tid_d      = tid_q;
    ptr_d      = ptr_q;
    cnt_d      = cnt_q;
    rd_d       = rd_q;
    wr_d       = wr_q;
    rej_d      = rej_q;
    chk_v_d    = chk_v_q;
    in_ready_o = 1'b0;
    emit       = 1'b0;
    emit_data  = '0;
    tbl_wr     = '0;
    cnt_we     = 1'b0;
    mem_we     = 1'b0;
    mem_waddr  = base + AW'(wr_q[IW-1:0]);
    mem_wdata  = mem_rdata;
    mem_re     = 1'b0;
    mem_raddr  = base + AW'(rd_q[IW-1:0]);

    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = out_free;
        if (in_valid_i && out_free) begin
          if (tid_ok && (in_data_i.cmd == CMD_RETIRE)) begin
            tid_d   = in_tid;
            ptr_d   = in_data_i.pointer_value;
            cnt_d   = counts_q[in_tid];
            rej_d   = (counts_q[in_tid] == CW'(RETIRE_DEPTH));
            rd_d    = '0;
            wr_d    = '0;
            chk_v_d = 1'b0;
            state_d = ST_SCAN;
          end else begin
            emit           = 1'b1;
            emit_data.kind = KIND_ACK;
            emit_data.last = 1'b1;
            if (tid_ok && slot_ok && (in_data_i.cmd == CMD_PROTECT)) begin
              emit_data.value = in_data_i.pointer_value;
            end
            tbl_wr.en        = tid_ok && (in_data_i.cmd != CMD_RETIRE) &&
                               ((in_data_i.cmd == CMD_CLEAR_ROW) || slot_ok);
            tbl_wr.whole_row = (in_data_i.cmd == CMD_CLEAR_ROW);
            tbl_wr.row       = SelW'(in_data_i.thread_id);
            tbl_wr.col       = SelW'(in_data_i.slot_index);
            tbl_wr.data      = (in_data_i.cmd == CMD_PROTECT) ?
                               in_data_i.pointer_value : '0;
          end
        end
      end
      ST_SCAN: begin
        if (chk_v_q && adv) begin
          if (hit) begin
            mem_we = 1'b1;
            wr_d   = wr_q + CW'(1);
          end else begin
            emit            = 1'b1;
            emit_data.kind  = KIND_FREED;
            emit_data.value = mem_rdata;
          end
        end
        if (adv) begin
          if (rd_q != cnt_q) begin
            mem_re  = 1'b1;
            rd_d    = rd_q + CW'(1);
            chk_v_d = 1'b1;
          end else begin
            chk_v_d = 1'b0;
            state_d = rej_q ? ST_FINAL : ST_TAIL;
          end
        end
      end
      ST_TAIL: begin
        if (hit) begin
          mem_we    = 1'b1;
          mem_wdata = ptr_q;
          wr_d      = wr_q + CW'(1);
          state_d   = ST_FINAL;
        end else if (out_free) begin
          emit            = 1'b1;
          emit_data.kind  = KIND_FREED;
          emit_data.value = ptr_q;
          state_d         = ST_FINAL;
        end
      end
      ST_FINAL: begin
        if (out_free) begin
          emit           = 1'b1;
          emit_data.last = 1'b1;
          if (rej_q) begin
            emit_data.kind  = KIND_OVERFLOW;
            emit_data.value = ptr_q;
          end else begin
            emit_data.kind  = KIND_ACK;
            emit_data.value = PtrW'(wr_q);
          end
          cnt_we  = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      chk_v_q     <= 1'b0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < THREADS; i++) begin
        counts_q[i] <= '0;
      end
    end else begin
      state_q <= state_d;
      chk_v_q <= chk_v_d;
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (cnt_we) begin
        counts_q[tid_q] <= wr_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    tid_q <= tid_d;
    ptr_q <= ptr_d;
    cnt_q <= cnt_d;
    rd_q  <= rd_d;
    wr_q  <= wr_d;
    rej_q <= rej_d;
    if (emit) begin
      out_q <= emit_data;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire

// ===== rtl/core/hpr_hazard_table.sv =====
`timescale 1ns / 1ps
`default_nettype none

module hpr_hazard_table #(
  parameter int unsigned THREADS = hpr_pkg::DefThreads,
  parameter int unsigned SLOTS   = hpr_pkg::DefSlots
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire hpr_pkg::slot_wr_t        wr_i,
  input  wire logic [hpr_pkg::PtrW-1:0] query_i,
  output logic                          hit_o
);

  import hpr_pkg::*;

  localparam int unsigned Entries = THREADS * SLOTS;

  logic [PtrW-1:0] slots_q [Entries];

  for (genvar r = 0; r < THREADS; r++) begin : g_row
    for (genvar c = 0; c < SLOTS; c++) begin : g_col
      always_ff @(posedge clk_i or negedge rst_ni) begin
        if (!rst_ni) begin
          slots_q[r*SLOTS+c] <= '0;
        end else if (wr_i.en && (wr_i.row == SelW'(r)) &&
                     (wr_i.whole_row || (wr_i.col == SelW'(c)))) begin
          slots_q[r*SLOTS+c] <= wr_i.data;
        end
      end
    end
  end

  always_comb begin
    hit_o = 1'b0;
    for (int i = 0; i < Entries; i++) begin
      if (slots_q[i] == query_i) begin
        hit_o = 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/hpr_retire_mem.sv =====
`timescale 1ns / 1ps
`default_nettype none

module hpr_retire_mem #(
  parameter int unsigned ENTRIES = hpr_pkg::DefThreads * hpr_pkg::DefRetireDepth,
  parameter int unsigned AW      = $clog2(ENTRIES)
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [AW-1:0]            waddr_i,
  input  wire logic [hpr_pkg::PtrW-1:0] wdata_i,
  input  wire logic                     re_i,
  input  wire logic [AW-1:0]            raddr_i,
  output logic      [hpr_pkg::PtrW-1:0] rdata_o
);

  import hpr_pkg::*;

  logic [PtrW-1:0] mem [ENTRIES];
  logic [PtrW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== test/tb.sv =====
`timescale 1ns / 1ps

module tb;
  import hpr_pkg::*;

  localparam int unsigned NumThreads = DefThreads;
  localparam int unsigned NumSlots   = DefSlots;
  localparam int unsigned ListDepth  = DefRetireDepth;
  localparam int unsigned PoolSize   = 6;
  localparam int unsigned PhaseItems = 120;
  localparam int unsigned HoldCycles = 300;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic in_valid = 1'b0;
  logic in_ready;
  in_t  in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_t out_data;

  hazard_pointer_reclaimer u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_data_o (out_data)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  in_t         cmd_queue[$];
  out_t        pending_results[$];
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned fail_cnt = 0;
  logic        hold_go = 1'b0;
  int unsigned hold_left = 0;
  logic [PtrW-1:0] ptr_pool[PoolSize];

  // Shadow copy of the hazard table and the per-thread retire lists.
  logic [PtrW-1:0] hazard_tbl[NumThreads*NumSlots];
  logic [PtrW-1:0] retire_mem[NumThreads][ListDepth];
  int unsigned     retire_cnt[NumThreads];

  function automatic bit is_held(logic [PtrW-1:0] p);
    for (int i = 0; i < NumThreads * NumSlots; i++) begin
      if (hazard_tbl[i] == p) return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic out_t make_result(logic [1:0] kind, logic [PtrW-1:0] value, logic last);
    out_t r;
    r.kind  = kind;
    r.value = value;
    r.last  = last;
    return r;
  endfunction

  task automatic compute_results(input in_t it);
    int unsigned t;
    int unsigned n;
    int unsigned wr;
    bit full;
    logic [PtrW-1:0] p;
    t = it.thread_id;
    if (t >= NumThreads) begin
      pending_results.push_back(make_result(KIND_ACK, '0, 1'b1));
    end else begin
      case (it.cmd)
        CMD_PROTECT: begin
          if (it.slot_index >= NumSlots) begin
            pending_results.push_back(make_result(KIND_ACK, '0, 1'b1));
          end else begin
            hazard_tbl[t*NumSlots + it.slot_index] = it.pointer_value;
            pending_results.push_back(make_result(KIND_ACK, it.pointer_value, 1'b1));
          end
        end
        CMD_CLEAR_ONE: begin
          if (it.slot_index < NumSlots) hazard_tbl[t*NumSlots + it.slot_index] = '0;
          pending_results.push_back(make_result(KIND_ACK, '0, 1'b1));
        end
        CMD_CLEAR_ROW: begin
          for (int s = 0; s < NumSlots; s++) hazard_tbl[t*NumSlots + s] = '0;
          pending_results.push_back(make_result(KIND_ACK, '0, 1'b1));
        end
        default: begin
          n = retire_cnt[t];
          full = (n >= ListDepth);
          if (!full) begin
            retire_mem[t][n] = it.pointer_value;
            n++;
          end
          wr = 0;
          for (int rd = 0; rd < n; rd++) begin
            p = retire_mem[t][rd];
            if (is_held(p)) begin
              retire_mem[t][wr] = p;
              wr++;
            end else begin
              pending_results.push_back(make_result(KIND_FREED, p, 1'b0));
            end
          end
          retire_cnt[t] = wr;
          if (full) begin
            pending_results.push_back(make_result(KIND_OVERFLOW, it.pointer_value, 1'b1));
          end else begin
            pending_results.push_back(make_result(KIND_ACK, PtrW'(wr), 1'b1));
          end
        end
      endcase
    end
  endtask

  task automatic push_item(cmd_e c, int unsigned tid, int unsigned slot, logic [PtrW-1:0] ptr);
    in_t it;
    it.cmd           = c;
    it.thread_id     = 2'(tid);
    it.slot_index    = 2'(slot);
    it.pointer_value = ptr;
    cmd_queue.push_back(it);
  endtask

  // Mostly pool pointers, so that protects and retires meet and lists fill up.
  function automatic in_t random_item();
    in_t it;
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 30) it.cmd = CMD_PROTECT;
    else if (pick < 45) it.cmd = CMD_CLEAR_ONE;
    else if (pick < 50) it.cmd = CMD_CLEAR_ROW;
    else it.cmd = CMD_RETIRE;
    it.thread_id  = 2'($urandom_range(3));
    it.slot_index = 2'($urandom_range(3));
    pick = $urandom_range(99);
    if (pick < 80) it.pointer_value = ptr_pool[$urandom_range(PoolSize-1)];
    else if (pick < 90) it.pointer_value = {$urandom, $urandom};
    else it.pointer_value = '0;
    return it;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
      in_data  <= '0;
    end else if (!in_valid || in_ready) begin
      if (in_valid) compute_results(in_data);
      if (cmd_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        in_valid <= 1'b1;
        in_data  <= cmd_queue.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin
    if (hold_go) hold_left <= HoldCycles;
    else if (hold_left != 0) hold_left <= hold_left - 1;
  end

  always @(posedge clk_i or negedge rst_ni) begin
    out_t want;
    if (!rst_ni) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (pending_results.size() == 0) begin
          if (fail_cnt < 10) begin
            $display("unexpected result: kind %0d value %h last %0d",
                     out_data.kind, out_data.value, out_data.last);
          end
          fail_cnt++;
        end else begin
          want = pending_results.pop_front();
          if (out_data !== want) begin
            if (fail_cnt < 10) begin
              $display("mismatch: expected kind %0d value %h last %0d, got kind %0d value %h last %0d",
                       want.kind, want.value, want.last,
                       out_data.kind, out_data.value, out_data.last);
            end
            fail_cnt++;
          end
        end
      end
      out_ready <= (hold_left == 0) && ($urandom_range(99) >= recv_stall_pct);
    end
  end

  initial begin
    #5_000_000;
    $display("** hazard_pointer_reclaimer: FAILED **");
    $finish;
  end

  initial begin
    for (int i = 0; i < NumThreads * NumSlots; i++) hazard_tbl[i] = '0;
    for (int i = 0; i < NumThreads; i++) retire_cnt[i] = 0;
    for (int i = 0; i < PoolSize; i++) ptr_pool[i] = {$urandom, $urandom};
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    for (int phase = 0; phase < 3; phase++) begin
      @(negedge clk_i);
      case (phase)
        0: begin
          send_idle_pct  = 15;
          recv_stall_pct = 51;
        end
        1: begin
          send_idle_pct  = 51;
          recv_stall_pct = 15;
        end
        default: begin
          send_idle_pct  = 0;
          recv_stall_pct = 0;
        end
      endcase
      if (phase == 0) begin
        // A zero pointer stays listed while any slot is clear. The tail fills
        // thread 0's list with one protected pointer, overflows it, then drops
        // the protection so that one retire frees the whole list.
        push_item(CMD_PROTECT, 3, 3, 64'h8000_0000_0000_0001);
        push_item(CMD_PROTECT, 0, 0, '1);
        push_item(CMD_RETIRE, 1, 2, '1);
        push_item(CMD_RETIRE, 1, 1, '0);
        push_item(CMD_CLEAR_ONE, 0, 0, 64'h1234);
        push_item(CMD_RETIRE, 1, 0, 64'h5);
        for (int i = 0; i < ListDepth; i++) begin
          push_item(CMD_RETIRE, 0, i % 4, 64'h8000_0000_0000_0001);
        end
        push_item(CMD_RETIRE, 0, 3, 64'hfedc_ba98_7654_3210);
        push_item(CMD_CLEAR_ROW, 3, 0, 64'h7fff_ffff_ffff_fffe);
        push_item(CMD_RETIRE, 0, 0, '0);
        push_item(CMD_RETIRE, 2, 1, 64'h3c);
      end
      for (int i = 0; i < PhaseItems; i++) cmd_queue.push_back(random_item());
      if (phase == 2) begin
        hold_go = 1'b1;
        @(negedge clk_i);
        hold_go = 1'b0;
      end
      while (cmd_queue.size() != 0 || in_valid || pending_results.size() != 0) begin
        @(negedge clk_i);
      end
    end

    repeat (ListDepth + 10) @(negedge clk_i);
    if (pending_results.size() != 0) fail_cnt++;
    if (fail_cnt == 0) begin
      $display("** hazard_pointer_reclaimer: PASSED **");
    end else begin
      $display("** hazard_pointer_reclaimer: FAILED **");
    end
    $finish;
  end

endmodule
